### hw/rtl/mrc_pkg.sv
`timescale 1ns / 1ps
package mrc_pkg;

  // field and register widths
  localparam int IDX_W      = 16;
  localparam int COORD_W    = 4;
  localparam int RADIX_W    = 5;
  localparam int DIM_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;
  localparam int NUM_PORTS  = 4;

  localparam int MAX_DIMS   = 4;
  localparam int RADIX_BITS = 4;

  localparam int USED_MAX   = (MAX_DIMS < NUM_PORTS) ? MAX_DIMS : NUM_PORTS;
  localparam int RADIX_FULL = (1 << RADIX_W) - 1;
  localparam int RADIX_CAP  = ((1 << RADIX_BITS) < RADIX_FULL) ? (1 << RADIX_BITS)
                                                               : RADIX_FULL;

  // exact divide by reciprocal: q = (n * ceil(2^K / d)) >> K for n < 2^IDX_W, d <= RADIX_CAP
  localparam int DIV_SHIFT  = IDX_W + $clog2(RADIX_CAP);
  localparam int RECIP_W    = DIV_SHIFT + 1;
  localparam int STRIDE_W   = IDX_W + 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_0   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_1   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_2   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_3   = CFG_IDX_W'(4);

  localparam logic MODE_TO_INDEX = 1'b0;
  localparam logic MODE_TO_COORD = 1'b1;

  // one beat as it walks down the cell chain
  typedef struct packed {
    logic                                mode;
    logic                                err;
    logic [IDX_W-1:0]                    val;    // running sum or remaining index
    logic [STRIDE_W-1:0]                 stride;
    logic [NUM_PORTS-1:0][COORD_W-1:0]   coord;  // rotates one slot per cell
  } beat_t;

endpackage

### hw/rtl/mixed_radix_index_converter.sv
`timescale 1ns / 1ps
// Channel   | Handshake            | Payload
// ----------+----------------------+-------------------------------------------------
// input     | start, busy          | mode, coord_in_0..3, index_in
// result    | done                 | index_out, coord_out_0..3, range_error
// config    | cfg_write            | cfg_index, cfg_data
//
// One beat per cycle; busy stays low. The result passes through two register stages
// in each of the four dimension cells, then through the output register.
// Synchronous reset clears the pipeline valids and sets dim_count to
// 1 and every radix to 2. The receiver cannot stall: done lasts one cycle.
module mixed_radix_index_converter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           mode,
  input  logic [mrc_pkg::COORD_W-1:0]    coord_in_0,
  input  logic [mrc_pkg::COORD_W-1:0]    coord_in_1,
  input  logic [mrc_pkg::COORD_W-1:0]    coord_in_2,
  input  logic [mrc_pkg::COORD_W-1:0]    coord_in_3,
  input  logic [mrc_pkg::IDX_W-1:0]      index_in,
  input  logic                           cfg_write,
  input  logic [mrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           done,
  output logic [mrc_pkg::IDX_W-1:0]      index_out,
  output logic [mrc_pkg::COORD_W-1:0]    coord_out_0,
  output logic [mrc_pkg::COORD_W-1:0]    coord_out_1,
  output logic [mrc_pkg::COORD_W-1:0]    coord_out_2,
  output logic [mrc_pkg::COORD_W-1:0]    coord_out_3,
  output logic                           range_error
);
  import mrc_pkg::*;

  logic [DIM_W-1:0]   dim_count;
  logic [RADIX_W-1:0] radix_reg [NUM_PORTS];

  logic [DIM_W-1:0]   used_n;
  logic [RADIX_W-1:0] eff_radix [NUM_PORTS];
  logic               used      [NUM_PORTS];

  logic               valid_chain [NUM_PORTS+1];
  beat_t              beat_chain  [NUM_PORTS+1];
  beat_t              last;
  logic               last_err;
  logic               last_ok;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count <= DIM_W'(1);
      for (int i = 0; i < NUM_PORTS; i++) begin
        radix_reg[i] <= RADIX_W'(2);
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DIM_COUNT: dim_count    <= cfg_data[DIM_W-1:0];
        REG_RADIX_0:   radix_reg[0] <= cfg_data[RADIX_W-1:0];
        REG_RADIX_1:   radix_reg[1] <= cfg_data[RADIX_W-1:0];
        REG_RADIX_2:   radix_reg[2] <= cfg_data[RADIX_W-1:0];
        REG_RADIX_3:   radix_reg[3] <= cfg_data[RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp dimension count and radices; unused dimensions act as radix one
  always_comb begin
    if (dim_count == '0) begin
      used_n = DIM_W'(1);
    end else if (dim_count > DIM_W'(USED_MAX)) begin
      used_n = DIM_W'(USED_MAX);
    end else begin
      used_n = dim_count;
    end
    for (int i = 0; i < NUM_PORTS; i++) begin
      used[i] = (DIM_W'(i) < used_n);
      if (!used[i] || radix_reg[i] == '0) begin
        eff_radix[i] = RADIX_W'(1);
      end else if (radix_reg[i] > RADIX_W'(RADIX_CAP)) begin
        eff_radix[i] = RADIX_W'(RADIX_CAP);
      end else begin
        eff_radix[i] = radix_reg[i];
      end
    end
  end

  always_comb begin
    valid_chain[0]       = start;
    beat_chain[0].mode   = mode;
    beat_chain[0].err    = 1'b0;
    beat_chain[0].val    = (mode == MODE_TO_COORD) ? index_in : '0;
    beat_chain[0].stride = STRIDE_W'(1);
    beat_chain[0].coord  = {coord_in_3, coord_in_2, coord_in_1, coord_in_0};
  end

  genvar g;
  for (g = 0; g < NUM_PORTS; g++) begin : g_cell
    mrc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_chain[g]),
      .in_beat   (beat_chain[g]),
      .radix     (eff_radix[g]),
      .used      (used[g]),
      .out_valid (valid_chain[g+1]),
      .out_beat  (beat_chain[g+1])
    );
  end

  // index is in range only if nothing is left after dividing by every radix
  always_comb begin
    last     = beat_chain[NUM_PORTS];
    last_ok  = (last.mode == MODE_TO_COORD) && (last.val == '0);
    last_err = (last.mode == MODE_TO_COORD) ? (last.val != '0) : last.err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_chain[NUM_PORTS];
    end
  end

  always_ff @(posedge clk) begin
    index_out   <= (last.mode == MODE_TO_INDEX) ? last.val : '0;
    coord_out_0 <= last_ok ? last.coord[0] : '0;
    coord_out_1 <= last_ok ? last.coord[1] : '0;
    coord_out_2 <= last_ok ? last.coord[2] : '0;
    coord_out_3 <= last_ok ? last.coord[3] : '0;
    range_error <= last_err;
  end

endmodule

### hw/rtl/mrc_cell.sv
`timescale 1ns / 1ps
module mrc_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  mrc_pkg::beat_t               in_beat,
  input  logic [mrc_pkg::RADIX_W-1:0]  radix,
  input  logic                         used,
  output logic                         out_valid,
  output mrc_pkg::beat_t               out_beat
);
  import mrc_pkg::*;

  localparam int ROM_DEPTH = 1 << RADIX_W;

  logic [RECIP_W-1:0]                recip_rom [ROM_DEPTH];
  logic [COORD_W+STRIDE_W-1:0]       term_full;
  logic [STRIDE_W+RADIX_W-1:0]       stride_full;
  logic [IDX_W+RECIP_W-1:0]          quot_full;
  logic                              coord_err;
  beat_t                             mid_beat_next;

  logic                              mid_valid;
  beat_t                             mid_beat;
  logic [IDX_W-1:0]                  mid_quot;

  logic [2*RADIX_W-1:0]              back_full;
  logic [RADIX_W-1:0]                rem_low;
  logic [COORD_W-1:0]                digit;
  beat_t                             out_beat_next;

  genvar d;
  for (d = 0; d < ROM_DEPTH; d++) begin : g_recip
    if (d == 0) begin : g_zero
      assign recip_rom[d] = '0;
    end else begin : g_val
      localparam logic [RECIP_W-1:0] RV =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(d) - 64'd1) / 64'(d));
      assign recip_rom[d] = RV;
    end
  end

  // first half: coordinate term and stride, or quotient by reciprocal
  always_comb begin
    term_full   = (COORD_W+STRIDE_W)'(in_beat.coord[0]) * (COORD_W+STRIDE_W)'(in_beat.stride);
    stride_full = (STRIDE_W+RADIX_W)'(in_beat.stride) * (STRIDE_W+RADIX_W)'(radix);
    quot_full   = (IDX_W+RECIP_W)'(in_beat.val) * (IDX_W+RECIP_W)'(recip_rom[radix]);
    coord_err   = (RADIX_W'(in_beat.coord[0]) >= radix);
    mid_beat_next = in_beat;
    if (in_beat.mode == MODE_TO_INDEX) begin
      if (used) begin
        mid_beat_next.val = in_beat.val + term_full[IDX_W-1:0];
      end
      mid_beat_next.err    = in_beat.err | coord_err;
      mid_beat_next.stride = stride_full[STRIDE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    mid_beat <= mid_beat_next;
    mid_quot <= quot_full[DIV_SHIFT +: IDX_W];
  end

  // second half: remainder digit from the low bits only, digit is below the radix
  always_comb begin
    back_full = (2*RADIX_W)'(mid_quot[RADIX_W-1:0]) * (2*RADIX_W)'(radix);
    rem_low   = mid_beat.val[RADIX_W-1:0] - back_full[RADIX_W-1:0];
    digit     = (mid_beat.mode == MODE_TO_COORD) ? rem_low[COORD_W-1:0] : mid_beat.coord[0];
    out_beat_next       = mid_beat;
    out_beat_next.coord = {digit, mid_beat.coord[NUM_PORTS-1:1]};
    if (mid_beat.mode == MODE_TO_COORD) begin
      out_beat_next.val = mid_quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_beat <= out_beat_next;
  end

endmodule
